/* rtl/lip_pkg.sv */
package lip_pkg;

  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_GRANT     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OPEN      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  localparam logic CMD_PICK    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // capture request, clear scan results
    logic rd_en;     // table read at rd_addr
    logic rd_shift;  // read belongs to the compaction sweep
    logic commit;    // apply decision, write table, load result
  } lip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_release;
    logic out_free;
    logic match_found;
    logic match_exh;
    logic match_last;
  } lip_status_t;

endpackage

/* rtl/lip_ctrl.sv */
module lip_ctrl
  import lip_pkg::*;
#(
  parameter int MAX_OPEN = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lip_status_t                st,
  input  logic [$clog2(MAX_OPEN+1)-1:0] length,
  input  logic [((MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1)-1:0] match_idx,
  output lip_cmd_t                   cmd,
  output logic [((MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1)-1:0] rd_addr
);

  localparam int IW = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
  localparam int LW = $clog2(MAX_OPEN + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_SHIFT, S_SDRAIN
  } state_t;

  state_t        state;
  logic [LW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt   <= '0;
            state <= (length == '0) ? S_COMMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + LW'(1);
          if (cnt + LW'(1) == length) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_COMMIT;
        S_COMMIT: begin
          if (!st.is_release) begin
            if (st.out_free) state <= S_IDLE;
          end else if (st.match_found && st.match_exh && !st.match_last) begin
            cnt   <= LW'(match_idx) + LW'(1);
            state <= S_SHIFT;
          end else begin
            state <= S_IDLE;
          end
        end
        // length already shrunk here, so the last old entry sits at index length
        S_SHIFT: begin
          cnt <= cnt + LW'(1);
          if (cnt == length) state <= S_SDRAIN;
        end
        S_SDRAIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.load_in  = in_valid && (state == S_IDLE);
    cmd.rd_en    = (state == S_SCAN) || (state == S_SHIFT);
    cmd.rd_shift = (state == S_SHIFT);
    cmd.commit   = (state == S_COMMIT) && (st.is_release || st.out_free);
    rd_addr      = cnt[IW-1:0];
  end

endmodule

/* rtl/lip_datapath.sv */
module lip_datapath
  import lip_pkg::*;
#(
  parameter int MAX_OPEN   = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_cmd,
  input  logic                  in_avail,
  input  logic                  in_par,
  input  logic [HANDLE_W-1:0]   in_handle,
  input  logic                  in_exh,
  input  lip_cmd_t              cmd,
  input  logic [((MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1)-1:0] rd_addr,
  output lip_status_t           st,
  output logic [$clog2(MAX_OPEN+1)-1:0] length,
  output logic [((MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1)-1:0] match_idx,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [HANDLE_W-1:0]   out_handle,
  output logic                  out_par
);

  localparam int IW = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
  localparam int LW = $clog2(MAX_OPEN + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // table storage
  logic [HANDLE_W-1:0]   mem_handle [MAX_OPEN];
  logic                  mem_par    [MAX_OPEN];
  logic [COUNT_BITS-1:0] mem_calls  [MAX_OPEN];

  logic                  rd_valid_q, rd_shift_q;
  logic [IW-1:0]         rd_idx_q;
  logic [HANDLE_W-1:0]   rd_handle_q;
  logic                  rd_par_q;
  logic [COUNT_BITS-1:0] rd_calls_q;

  // captured request
  logic                  cmd_q, avail_q, par_q, exh_q;
  logic [HANDLE_W-1:0]   rh_q;

  logic [HANDLE_W-1:0]   next_handle;

  // scan results
  logic                  found_idle, have_best, match_found;
  logic [IW-1:0]         idle_idx, best_idx;
  logic [HANDLE_W-1:0]   idle_handle, best_handle;
  logic                  idle_par, best_par;
  logic [COUNT_BITS-1:0] best_calls, match_calls;

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [HANDLE_W-1:0]   wr_handle;
  logic                  wr_par;
  logic [COUNT_BITS-1:0] wr_calls;
  logic                  pick_commit, open_new, shrink;
  logic [STATUS_W-1:0]   res_status;
  logic [HANDLE_W-1:0]   res_handle;
  logic                  res_par;
  logic                  better, scan_hit;

  assign scan_hit = rd_valid_q && !rd_shift_q;
  assign better   = (rd_par_q && !best_par) ||
                    ((rd_par_q == best_par) && (rd_calls_q < best_calls));

  always_comb begin
    pick_commit = cmd.commit && (cmd_q == CMD_PICK);
    open_new    = 1'b0;
    shrink      = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = rd_idx_q - IW'(1);
    wr_handle   = rd_handle_q;
    wr_par      = rd_par_q;
    wr_calls    = rd_calls_q;
    res_status  = ST_GRANT;
    res_handle  = best_handle;
    res_par     = best_par;
    if (rd_valid_q && rd_shift_q) begin
      wr_en = 1'b1;
    end else if (pick_commit) begin
      priority if (found_idle) begin
        wr_en      = 1'b1;
        wr_addr    = idle_idx;
        wr_handle  = idle_handle;
        wr_par     = idle_par;
        wr_calls   = COUNT_BITS'(1);
        res_handle = idle_handle;
        res_par    = idle_par;
      end else if (avail_q && (length != LW'(MAX_OPEN))) begin
        open_new   = 1'b1;
        wr_en      = 1'b1;
        wr_addr    = length[IW-1:0];
        wr_handle  = next_handle;
        wr_par     = par_q;
        wr_calls   = COUNT_BITS'(1);
        res_status = ST_OPEN;
        res_handle = next_handle;
        res_par    = par_q;
      end else if (length == '0) begin
        res_status = ST_EXHAUSTED;
        res_handle = '0;
        res_par    = 1'b0;
      end else begin
        wr_en     = 1'b1;
        wr_addr   = best_idx;
        wr_handle = best_handle;
        wr_par    = best_par;
        wr_calls  = (best_calls == CNT_MAX) ? CNT_MAX : best_calls + COUNT_BITS'(1);
      end
    end else if (cmd.commit && match_found) begin
      // release: drop the entry when exhausted, else saturating decrement
      if (exh_q) begin
        shrink = 1'b1;
      end else begin
        wr_en     = 1'b1;
        wr_addr   = match_idx;
        wr_handle = rh_q;
        wr_par    = best_par;
        wr_calls  = (match_calls == '0) ? '0 : match_calls - COUNT_BITS'(1);
      end
    end
  end

  // release write must keep the flag of the matched entry: use a masked write
  logic wr_keep_par;
  assign wr_keep_par = cmd.commit && (cmd_q == CMD_RELEASE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_handle[wr_addr] <= wr_handle;
      mem_calls[wr_addr]  <= wr_calls;
      if (!wr_keep_par) mem_par[wr_addr] <= wr_par;
    end
    if (cmd.rd_en) begin
      rd_handle_q <= mem_handle[rd_addr];
      rd_par_q    <= mem_par[rd_addr];
      rd_calls_q  <= mem_calls[rd_addr];
    end
    rd_idx_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid_q  <= 1'b0;
      rd_shift_q  <= 1'b0;
      length      <= '0;
      next_handle <= '0;
      out_valid   <= 1'b0;
      found_idle  <= 1'b0;
      have_best   <= 1'b0;
      match_found <= 1'b0;
      cmd_q       <= CMD_PICK;
    end else begin
      rd_valid_q <= cmd.rd_en;
      rd_shift_q <= cmd.rd_shift;
      if (open_new) begin
        length      <= length + LW'(1);
        next_handle <= next_handle + HANDLE_W'(1);
      end else if (shrink) begin
        length <= length - LW'(1);
      end
      if (pick_commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.load_in) begin
        cmd_q       <= in_cmd;
        found_idle  <= 1'b0;
        have_best   <= 1'b0;
        match_found <= 1'b0;
      end else if (scan_hit) begin
        if (!found_idle && (rd_calls_q == '0)) found_idle <= 1'b1;
        have_best <= 1'b1;
        if (!match_found && (rd_handle_q == rh_q)) match_found <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      avail_q <= in_avail;
      par_q   <= in_par;
      rh_q    <= in_handle;
      exh_q   <= in_exh;
    end
    if (scan_hit) begin
      if (!found_idle && (rd_calls_q == '0)) begin
        idle_idx    <= rd_idx_q;
        idle_handle <= rd_handle_q;
        idle_par    <= rd_par_q;
      end
      if (!have_best || better) begin
        best_idx    <= rd_idx_q;
        best_handle <= rd_handle_q;
        best_par    <= rd_par_q;
        best_calls  <= rd_calls_q;
      end
      if (!match_found && (rd_handle_q == rh_q)) begin
        match_idx   <= rd_idx_q;
        match_calls <= rd_calls_q;
      end
    end
    if (pick_commit) begin
      out_status <= res_status;
      out_handle <= res_handle;
      out_par    <= res_par;
    end
  end

  always_comb begin
    st.is_release  = (cmd_q == CMD_RELEASE);
    st.out_free    = !out_valid || out_ready;
    st.match_found = match_found;
    st.match_exh   = exh_q;
    st.match_last  = (LW'(match_idx) + LW'(1) == length);
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LW'(MAX_OPEN))
    else $error("table length above capacity");

  a_pick_result: assert property (@(posedge clk) disable iff (rst)
    pick_commit |=> out_valid)
    else $error("pick finished without a result");

  a_handle_open: assert property (@(posedge clk) disable iff (rst)
    open_new |=> (next_handle == $past(next_handle) + HANDLE_W'(1)) &&
                 (length == $past(length) + LW'(1)))
    else $error("opening did not append an entry");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_valid_q && rd_shift_q) |-> !cmd.commit)
    else $error("compaction write collides with commit");

endmodule

/* rtl/least_loaded_source_picker_top.sv */
// a request is taken only when idle, one at a time; the table is then scanned one entry
//   a cycle through its read port, then committed (an empty table skips the scan)
// a pick waits in commit until the result register is free; a release that removes an
//   entry other than the last adds a compaction sweep that moves each later entry down
// reset: synchronous, active high; clears table length, handle counter and output valid
module least_loaded_source_picker_top
  import lip_pkg::*;
#(
  parameter int MAX_OPEN   = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // file_available, file_parallel, release_handle[15:0],
                                 // was_exhausted, zero fill
  input  logic [0:0]  s_tuser,   // cmd
  // result stream, one transfer per pick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // granted_handle[15:0], granted_parallel, zero fill
  output logic [1:0]  m_tuser    // status
);

  localparam int IW = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
  localparam int LW = $clog2(MAX_OPEN + 1);

  lip_cmd_t      cmd;
  lip_status_t   st;
  logic [LW-1:0] length;
  logic [IW-1:0] match_idx;
  logic [IW-1:0] rd_addr;
  logic [HANDLE_W-1:0] granted_handle;
  logic          granted_parallel;

  // sequencer: accept, scan, decide, compact
  lip_ctrl #(
    .MAX_OPEN(MAX_OPEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .length   (length),
    .match_idx(match_idx),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  // table, scan compare, output register
  lip_datapath #(
    .MAX_OPEN  (MAX_OPEN),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (s_tuser[0]),
    .in_avail  (s_tdata[0]),
    .in_par    (s_tdata[1]),
    .in_handle (s_tdata[17:2]),
    .in_exh    (s_tdata[18]),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .st        (st),
    .length    (length),
    .match_idx (match_idx),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(m_tuser),
    .out_handle(granted_handle),
    .out_par   (granted_parallel)
  );

  // result packing, zero fill up to a whole byte
  assign m_tdata = {7'd0, granted_parallel, granted_handle};

endmodule
